### rtl/cfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, constants and CRC helpers of the CRC checked frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 48;

   localparam logic [7:0]  SOF_BYTE     = 8'hA5;
   localparam logic [7:0]  HDR_CRC_INIT = 8'hFF;
   localparam logic [15:0] FRM_CRC_INIT = 16'hFFFF;
   localparam logic [7:0]  BODY_MAX_LEN = 8'd247;

   // register indexes (paddr[4:2])
   localparam logic [2:0] REG_CRC8_POLY   = 3'd0;
   localparam logic [2:0] REG_CRC16_POLY  = 3'd1;
   localparam logic [2:0] REG_LEN_LIMIT   = 3'd2;
   localparam logic [2:0] REG_GIMBAL_CMD  = 3'd3;
   localparam logic [2:0] REG_GIMBAL_LEN  = 3'd4;
   localparam logic [2:0] REG_HBEAT_CMD   = 3'd5;
   localparam logic [2:0] REG_HBEAT_LEN   = 3'd6;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_SEQ,
      PH_HCRC,
      PH_BODY
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE,
      EV_LEN_REJECT,
      EV_HDR_CRC_BAD,
      EV_FRAME_GOOD,
      EV_FRAME_CRC_BAD
   } event_type;

   typedef enum logic [1:0] {
      MK_GIMBAL,
      MK_HEARTBEAT,
      MK_UNKNOWN
   } match_type;

   typedef struct packed {
      logic [7:0]  crc8_poly;
      logic [15:0] crc16_poly;
      logic [7:0]  length_limit;
      logic [15:0] gimbal_cmd;
      logic [7:0]  gimbal_len;
      logic [15:0] heartbeat_cmd;
      logic [7:0]  heartbeat_len;
   } cfg_type;

   typedef struct packed {
      event_type   event_res;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [15:0] command_id;
      logic [7:0]  payload_length;
      match_type   match_kind;
   } result_type;

   // bitwise reflected CRC-8, one byte
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc,
                                            input logic [7:0] b,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

   // bitwise reflected CRC-16, one byte
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                              input logic [7:0]  b,
                                              input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### rtl/cfr_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_csr
// APB-style register file holding the receiver configuration.
// ----------------------------------------------------------------------------
module cfr_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [cfr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [cfr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [cfr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready,
   output cfr_pkg::cfg_type                       cfg
);

   cfr_pkg::cfg_type cfg_ff;
   cfr_pkg::cfg_type cfg_in;
   logic [2:0]       reg_idx;
   logic             wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            cfr_pkg::REG_CRC8_POLY:  cfg_in.crc8_poly     = pwdata[7:0];
            cfr_pkg::REG_CRC16_POLY: cfg_in.crc16_poly    = pwdata[15:0];
            cfr_pkg::REG_LEN_LIMIT:  cfg_in.length_limit  = pwdata[7:0];
            cfr_pkg::REG_GIMBAL_CMD: cfg_in.gimbal_cmd    = pwdata[15:0];
            cfr_pkg::REG_GIMBAL_LEN: cfg_in.gimbal_len    = pwdata[7:0];
            cfr_pkg::REG_HBEAT_CMD:  cfg_in.heartbeat_cmd = pwdata[15:0];
            cfr_pkg::REG_HBEAT_LEN:  cfg_in.heartbeat_len = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc8_poly     <= 8'h8C;
         cfg_ff.crc16_poly    <= 16'h8408;
         cfg_ff.length_limit  <= 8'd200;
         cfg_ff.gimbal_cmd    <= 16'd0;
         cfg_ff.gimbal_len    <= 8'd0;
         cfg_ff.heartbeat_cmd <= 16'd0;
         cfg_ff.heartbeat_len <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         cfr_pkg::REG_CRC8_POLY:  prdata = {24'd0, cfg_ff.crc8_poly};
         cfr_pkg::REG_CRC16_POLY: prdata = {16'd0, cfg_ff.crc16_poly};
         cfr_pkg::REG_LEN_LIMIT:  prdata = {24'd0, cfg_ff.length_limit};
         cfr_pkg::REG_GIMBAL_CMD: prdata = {16'd0, cfg_ff.gimbal_cmd};
         cfr_pkg::REG_GIMBAL_LEN: prdata = {24'd0, cfg_ff.gimbal_len};
         cfr_pkg::REG_HBEAT_CMD:  prdata = {16'd0, cfg_ff.heartbeat_cmd};
         cfr_pkg::REG_HBEAT_LEN:  prdata = {24'd0, cfg_ff.heartbeat_len};
         default:                 prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

### rtl/crc_checked_frame_receiver.sv
// CRC-8/CRC-16 update and parser are combinational; each result is then registered.
// Throughput: one byte per cycle while the skid entry is empty.
// A two-entry output buffer (result register plus skid entry) lets a byte be
//   taken while the previous result still waits on rsp_tready.
// Reset: synchronous, active high; parser returns to start-byte hunt, output
//   buffer empties, registers take their documented defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver
// Byte-serial deframer: start byte, length, sequence, header CRC-8, command
// id, payload and frame CRC-16; one result transaction per received byte.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input byte stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,  // [7:0] rx_byte
   // result stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [2:0] event_res, [10:3] payload_byte, [18:11] payload_index,
   // [34:19] command_id, [42:35] payload_length, [44:43] match_kind, rest 0
   output logic [cfr_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                    rsp_tuser,  // [0] payload_valid
   // configuration port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [cfr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [cfr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [cfr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready
);

   cfr_pkg::cfg_type cfg;

   cfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // ------------------------------------------------------------------
   // parser state
   // ------------------------------------------------------------------
   cfr_pkg::phase_type phase_ff,        phase_in;
   logic [7:0]         byte_count_ff,   byte_count_in;
   logic [7:0]         length_reg_ff,   length_reg_in;
   logic [7:0]         length_low_ff,   length_low_in;
   logic [7:0]         header_crc_ff,   header_crc_in;
   logic [15:0]        frame_crc_ff,    frame_crc_in;
   logic [15:0]        command_reg_ff,  command_reg_in;
   logic [7:0]         crc_low_byte_ff, crc_low_byte_in;

   cfr_pkg::result_type res;

   logic        push;
   logic        pop;
   logic [7:0]  rx_byte;
   logic [7:0]  hcrc_next;
   logic [15:0] fcrc_next;
   logic        len_bad;
   logic [8:0]  body_end;      // length + 2: command id plus payload
   logic [8:0]  count_ext;

   assign rx_byte   = req_tdata;
   assign push      = req_tvalid && req_tready;
   assign pop       = rsp_tvalid && rsp_tready;
   assign hcrc_next = cfr_pkg::crc8_feed(header_crc_ff, rx_byte, cfg.crc8_poly);
   assign fcrc_next = cfr_pkg::crc16_feed(frame_crc_ff, rx_byte, cfg.crc16_poly);
   assign body_end  = {1'b0, length_reg_ff} + 9'd2;
   assign count_ext = {1'b0, byte_count_ff};

   // whole 16-bit length is rejected if the high byte is set, at or above the limit
   // register, or beyond what the 8-bit body counter can track
   assign len_bad = (rx_byte != 8'd0) || (length_low_ff >= cfg.length_limit) ||
                    (length_low_ff > cfr_pkg::BODY_MAX_LEN);

   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      length_reg_in   = length_reg_ff;
      length_low_in   = length_low_ff;
      header_crc_in   = header_crc_ff;
      frame_crc_in    = frame_crc_ff;
      command_reg_in  = command_reg_ff;
      crc_low_byte_in = crc_low_byte_ff;

      res.event_res      = cfr_pkg::EV_NONE;
      res.payload_valid  = 1'b0;
      res.payload_byte   = 8'd0;
      res.payload_index  = 8'd0;
      res.match_kind     = cfr_pkg::MK_UNKNOWN;

      case (phase_ff)
         cfr_pkg::PH_LEN_LO: begin
            length_low_in = rx_byte;
            header_crc_in = hcrc_next;
            frame_crc_in  = fcrc_next;
            phase_in      = cfr_pkg::PH_LEN_HI;
         end
         cfr_pkg::PH_LEN_HI: begin
            if (len_bad) begin
               res.event_res = cfr_pkg::EV_LEN_REJECT;
               phase_in      = cfr_pkg::PH_HUNT;
               byte_count_in = 8'd0;
            end else begin
               length_reg_in = length_low_ff;
               header_crc_in = hcrc_next;
               frame_crc_in  = fcrc_next;
               phase_in      = cfr_pkg::PH_SEQ;
            end
         end
         cfr_pkg::PH_SEQ: begin
            header_crc_in = hcrc_next;
            frame_crc_in  = fcrc_next;
            phase_in      = cfr_pkg::PH_HCRC;
         end
         cfr_pkg::PH_HCRC: begin
            byte_count_in = 8'd0;
            if (header_crc_ff != rx_byte) begin
               res.event_res = cfr_pkg::EV_HDR_CRC_BAD;
               phase_in      = cfr_pkg::PH_HUNT;
            end else begin
               frame_crc_in = fcrc_next;
               phase_in     = cfr_pkg::PH_BODY;
            end
         end
         cfr_pkg::PH_BODY: begin
            if (count_ext < body_end) begin
               frame_crc_in  = fcrc_next;
               byte_count_in = byte_count_ff + 8'd1;
               if (byte_count_ff == 8'd0) begin
                  command_reg_in = {8'd0, rx_byte};
               end else if (byte_count_ff == 8'd1) begin
                  command_reg_in = {rx_byte, command_reg_ff[7:0]};
               end else begin
                  res.payload_valid = 1'b1;
                  res.payload_byte  = rx_byte;
                  res.payload_index = byte_count_ff - 8'd2;
               end
            end else if (count_ext == body_end) begin
               crc_low_byte_in = rx_byte;
               byte_count_in   = byte_count_ff + 8'd1;
            end else begin
               // last byte: CRC high byte, frame verdict
               if ({rx_byte, crc_low_byte_ff} == frame_crc_ff) begin
                  res.event_res = cfr_pkg::EV_FRAME_GOOD;
                  if (command_reg_ff == cfg.gimbal_cmd &&
                      length_reg_ff == cfg.gimbal_len) begin
                     res.match_kind = cfr_pkg::MK_GIMBAL;
                  end else if (command_reg_ff == cfg.heartbeat_cmd &&
                               length_reg_ff == cfg.heartbeat_len) begin
                     res.match_kind = cfr_pkg::MK_HEARTBEAT;
                  end
               end else begin
                  res.event_res = cfr_pkg::EV_FRAME_CRC_BAD;
               end
               phase_in      = cfr_pkg::PH_HUNT;
               byte_count_in = 8'd0;
            end
         end
         default: begin
            // hunting: a start byte opens a new frame
            byte_count_in = 8'd0;
            if (rx_byte == cfr_pkg::SOF_BYTE) begin
               length_reg_in   = 8'd0;
               length_low_in   = 8'd0;
               command_reg_in  = 16'd0;
               crc_low_byte_in = 8'd0;
               header_crc_in   = cfr_pkg::crc8_feed(cfr_pkg::HDR_CRC_INIT, rx_byte,
                                                    cfg.crc8_poly);
               frame_crc_in    = cfr_pkg::crc16_feed(cfr_pkg::FRM_CRC_INIT, rx_byte,
                                                     cfg.crc16_poly);
               phase_in        = cfr_pkg::PH_LEN_LO;
            end else begin
               phase_in = cfr_pkg::PH_HUNT;
            end
         end
      endcase

      // frame context is reported from the updated state, but only for
      // bytes that arrived inside a frame
      if (phase_ff != cfr_pkg::PH_HUNT) begin
         res.command_id     = command_reg_in;
         res.payload_length = length_reg_in;
      end else begin
         res.command_id     = 16'd0;
         res.payload_length = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= cfr_pkg::PH_HUNT;
         byte_count_ff   <= 8'd0;
         length_reg_ff   <= 8'd0;
         length_low_ff   <= 8'd0;
         header_crc_ff   <= cfr_pkg::HDR_CRC_INIT;
         frame_crc_ff    <= cfr_pkg::FRM_CRC_INIT;
         command_reg_ff  <= 16'd0;
         crc_low_byte_ff <= 8'd0;
      end else if (push) begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         length_reg_ff   <= length_reg_in;
         length_low_ff   <= length_low_in;
         header_crc_ff   <= header_crc_in;
         frame_crc_ff    <= frame_crc_in;
         command_reg_ff  <= command_reg_in;
         crc_low_byte_ff <= crc_low_byte_in;
      end
   end

   // ------------------------------------------------------------------
   // output buffer: result register plus skid entry
   // ------------------------------------------------------------------
   cfr_pkg::result_type out_ff;
   cfr_pkg::result_type skid_ff;
   logic                out_valid_ff;
   logic                skid_valid_ff;

   // ready depends only on registered state
   assign req_tready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end else if (push) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.payload_valid;
   assign rsp_tdata  = {3'd0,
                        out_ff.match_kind,
                        out_ff.payload_length,
                        out_ff.command_id,
                        out_ff.payload_index,
                        out_ff.payload_byte,
                        out_ff.event_res};

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry filled while result register empty");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("output buffer not empty after reset");

   a_payload_no_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (out_ff.event_res == cfr_pkg::EV_NONE))
      else $error("payload transaction carries a frame event");

   a_match_only_good: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.match_kind != cfr_pkg::MK_UNKNOWN) |->
      (out_ff.event_res == cfr_pkg::EV_FRAME_GOOD))
      else $error("command match reported on a frame that is not good");

   a_hunt_after_verdict: assert property (@(posedge clock) disable iff (reset)
      (push && res.event_res != cfr_pkg::EV_NONE) |=> (phase_ff == cfr_pkg::PH_HUNT))
      else $error("parser left frame state after a frame event");
`endif

endmodule
`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for crc_checked_frame_receiver. Builds frames with
// their header CRC-8 and frame CRC-16, corrupts some, mixes in line noise,
// and compares every result transaction against a byte-level deframer model.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cfr_pkg::*;

   // index past the end of the register map; writes must be ignored
   localparam logic [2:0] REG_SPARE = 3'd7;

   typedef enum int {
      FRAME_INTACT,
      FRAME_BAD_HDR_CRC,
      FRAME_BAD_FRM_CRC
   } frame_fault_e;

   // ---------------------------------------------------------------- DUT I/O
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = 8'd0;   // [7:0] rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // [2:0] event_res, [10:3] payload_byte, [18:11] payload_index,
   // [34:19] command_id, [42:35] payload_length, [44:43] match_kind, rest 0
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;            // [0] payload_valid
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   crc_checked_frame_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------- deframer model
   // Register shadow, kept in step with every CSR write.
   cfg_type     cfg_model;
   // Parser state, advanced once per accepted byte.
   phase_type   rx_phase;
   logic [7:0]  body_count;
   logic [7:0]  len_reg;
   logic [7:0]  len_low_q;
   logic [7:0]  hdr_crc_q;
   logic [15:0] frm_crc_q;
   logic [15:0] cmd_q;
   logic [7:0]  crc_lo_q;

   // Results still owed by the DUT, oldest first.
   result_type  pending_rx_results[$];

   // Run control shared with the pacing processes.
   bit          src_idle_on  = 1'b1;
   bit          sink_idle_on = 1'b1;
   bit          hold_request = 1'b0;
   int unsigned hold_cycles  = 0;

   // Bookkeeping.
   int unsigned mismatch_count  = 0;
   int unsigned results_checked = 0;
   int unsigned bytes_sent      = 0;
   int unsigned frames_sent     = 0;
   int unsigned settings_used   = 0;
   int unsigned event_tally[5]  = '{default: 0};

   // Reflected CRCs, one input bit at a time (LSB first).
   function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] r;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         if (r[0] ^ data[k]) r = {1'b0, r[7:1]} ^ cfg_model.crc8_poly;
         else r = {1'b0, r[7:1]};
      end
      return r;
   endfunction

   function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         if (r[0] ^ data[k]) r = {1'b0, r[15:1]} ^ cfg_model.crc16_poly;
         else r = {1'b0, r[15:1]};
      end
      return r;
   endfunction

   // Advance the parser by one byte and return the result it owes.
   function automatic result_type deframe_byte(input logic [7:0] b);
      result_type  r;
      logic        in_frame;
      logic [15:0] len16;
      int unsigned cnt;
      int unsigned n;
      r.event_res      = EV_NONE;
      r.payload_valid  = 1'b0;
      r.payload_byte   = 8'd0;
      r.payload_index  = 8'd0;
      r.command_id     = 16'd0;
      r.payload_length = 8'd0;
      r.match_kind     = MK_UNKNOWN;
      in_frame = (rx_phase != PH_HUNT);
      case (rx_phase)
         PH_LEN_LO: begin
            len_low_q = b;
            hdr_crc_q = crc8_next(hdr_crc_q, b);
            frm_crc_q = crc16_next(frm_crc_q, b);
            rx_phase  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len16 = {b, len_low_q};
            // the fixed 247 ceiling applies whatever the limit register says
            if (len16 >= cfg_model.length_limit || len16 > BODY_MAX_LEN) begin
               r.event_res = EV_LEN_REJECT;
               rx_phase    = PH_HUNT;
               body_count  = 8'd0;
            end else begin
               len_reg   = len16[7:0];
               hdr_crc_q = crc8_next(hdr_crc_q, b);
               frm_crc_q = crc16_next(frm_crc_q, b);
               rx_phase  = PH_SEQ;
            end
         end
         PH_SEQ: begin
            hdr_crc_q = crc8_next(hdr_crc_q, b);
            frm_crc_q = crc16_next(frm_crc_q, b);
            rx_phase  = PH_HCRC;
         end
         PH_HCRC: begin
            if (hdr_crc_q != b) begin
               r.event_res = EV_HDR_CRC_BAD;
               rx_phase    = PH_HUNT;
               body_count  = 8'd0;
            end else begin
               frm_crc_q  = crc16_next(frm_crc_q, b);
               body_count = 8'd0;
               rx_phase   = PH_BODY;
            end
         end
         PH_BODY: begin
            cnt = body_count;
            n   = len_reg;
            if (cnt < n + 2) begin
               frm_crc_q = crc16_next(frm_crc_q, b);
               if (cnt == 0) cmd_q = {8'd0, b};
               else if (cnt == 1) cmd_q[15:8] = b;
               else begin
                  r.payload_valid = 1'b1;
                  r.payload_byte  = b;
                  r.payload_index = 8'(cnt - 2);
               end
               body_count = 8'(cnt + 1);
            end else if (cnt == n + 2) begin
               crc_lo_q   = b;
               body_count = 8'(cnt + 1);
            end else begin
               if ({b, crc_lo_q} == frm_crc_q) begin
                  r.event_res = EV_FRAME_GOOD;
                  // gimbal is tested first, so it wins when both match
                  if (cmd_q == cfg_model.gimbal_cmd && len_reg == cfg_model.gimbal_len)
                     r.match_kind = MK_GIMBAL;
                  else if (cmd_q == cfg_model.heartbeat_cmd &&
                           len_reg == cfg_model.heartbeat_len)
                     r.match_kind = MK_HEARTBEAT;
               end else begin
                  r.event_res = EV_FRAME_CRC_BAD;
               end
               rx_phase   = PH_HUNT;
               body_count = 8'd0;
            end
         end
         default: begin
            body_count = 8'd0;
            if (b == SOF_BYTE) begin
               len_reg   = 8'd0;
               len_low_q = 8'd0;
               cmd_q     = 16'd0;
               crc_lo_q  = 8'd0;
               hdr_crc_q = crc8_next(HDR_CRC_INIT, b);
               frm_crc_q = crc16_next(FRM_CRC_INIT, b);
               rx_phase  = PH_LEN_LO;
            end else begin
               rx_phase = PH_HUNT;
            end
         end
      endcase
      if (in_frame) begin
         r.command_id     = cmd_q;
         r.payload_length = len_reg;
      end
      return r;
   endfunction

   // ------------------------------------------------------- result checker
   // One transaction per accepted byte; compare against the oldest owed result.
   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.event_res      = event_type'(rsp_tdata[2:0]);
         seen.payload_valid  = rsp_tuser;
         seen.payload_byte   = rsp_tdata[10:3];
         seen.payload_index  = rsp_tdata[18:11];
         seen.command_id     = rsp_tdata[34:19];
         seen.payload_length = rsp_tdata[42:35];
         seen.match_kind     = match_type'(rsp_tdata[44:43]);
         results_checked++;
         if (pending_rx_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result transaction, tdata=%h tuser=%b",
                        $realtime, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_rx_results.pop_front();
            if (seen.event_res <= EV_FRAME_CRC_BAD) event_tally[seen.event_res]++;
            if (seen.event_res      !== want.event_res      ||
                seen.payload_valid  !== want.payload_valid  ||
                seen.payload_byte   !== want.payload_byte   ||
                seen.payload_index  !== want.payload_index  ||
                seen.command_id     !== want.command_id     ||
                seen.payload_length !== want.payload_length ||
                seen.match_kind     !== want.match_kind     ||
                rsp_tdata[RSP_DATA_W-1:45] !== '0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result %0d differs (ev pv byte idx cmd len match)",
                           $realtime, results_checked);
                  $display("   expected %0d %b %h %0d %h %0d %0d",
                           want.event_res, want.payload_valid, want.payload_byte,
                           want.payload_index, want.command_id, want.payload_length,
                           want.match_kind);
                  $display("   actual   %0d %b %h %0d %h %0d %0d pad=%b",
                           seen.event_res, seen.payload_valid, seen.payload_byte,
                           seen.payload_index, seen.command_id, seen.payload_length,
                           seen.match_kind, rsp_tdata[RSP_DATA_W-1:45]);
               end
            end
         end
      end
   end

   // ------------------------------------------------------- receiver pacing
   // Ready bursts and random stalls; a requested long hold is counted here.
   initial begin : sink_pacing
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_request = 1'b0;
         end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, sink_idle_on ? 16 : 1)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------- stimulus tasks
   // Offer one byte; on acceptance record the result it owes. tvalid stays
   // high so a following call can present the next byte in the same step.
   task automatic send_byte(input logic [7:0] b);
      if (src_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rx_results.push_back(deframe_byte(b));
      bytes_sent++;
   endtask

   // Drop tvalid and let every owed result drain before touching registers.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_rx_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB setup and access phases, then idle; the shadow follows the DUT's masking.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_CRC8_POLY:  cfg_model.crc8_poly     = val[7:0];
         REG_CRC16_POLY: cfg_model.crc16_poly    = val[15:0];
         REG_LEN_LIMIT:  cfg_model.length_limit  = val[7:0];
         REG_GIMBAL_CMD: cfg_model.gimbal_cmd    = val[15:0];
         REG_GIMBAL_LEN: cfg_model.gimbal_len    = val[7:0];
         REG_HBEAT_CMD:  cfg_model.heartbeat_cmd = val[15:0];
         REG_HBEAT_LEN:  cfg_model.heartbeat_len = val[7:0];
         default: ;
      endcase
   endtask

   // Full frame: SOF, length, sequence, header CRC, command, payload, CRC-16.
   // Lengths beyond the 247 ceiling carry only a short noise tail.
   task automatic send_frame(input logic [15:0] cmd, input logic [15:0] len16,
                             input frame_fault_e fault);
      logic [7:0]  frame_q[$];
      logic [7:0]  hcrc;
      logic [15:0] fcrc;
      int unsigned body_len;
      frame_q = {SOF_BYTE, len16[7:0], len16[15:8], 8'($urandom)};
      hcrc = HDR_CRC_INIT;
      foreach (frame_q[k]) hcrc = crc8_next(hcrc, frame_q[k]);
      if (fault == FRAME_BAD_HDR_CRC) hcrc ^= 8'($urandom_range(1, 255));
      frame_q.push_back(hcrc);
      frame_q.push_back(cmd[7:0]);
      frame_q.push_back(cmd[15:8]);
      body_len = (len16 > BODY_MAX_LEN) ? $urandom_range(0, 6) : len16;
      repeat (body_len) frame_q.push_back(8'($urandom));
      fcrc = FRM_CRC_INIT;
      foreach (frame_q[k]) fcrc = crc16_next(fcrc, frame_q[k]);
      if (fault == FRAME_BAD_FRM_CRC) fcrc ^= 16'($urandom_range(1, 65535));
      frame_q.push_back(fcrc[7:0]);
      frame_q.push_back(fcrc[15:8]);
      foreach (frame_q[k]) send_byte(frame_q[k]);
      frames_sent++;
   endtask

   // Zero, all ones or, mostly, random, so extreme polynomials and ids show up.
   function automatic logic [31:0] biased_word();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Largest acceptable length now and then, small ones otherwise.
   function automatic logic [15:0] pick_length();
      int unsigned top;
      top = (cfg_model.length_limit == 0) ? 0 : cfg_model.length_limit - 1;
      if (top > BODY_MAX_LEN) top = BODY_MAX_LEN;
      if ($urandom_range(0, 39) == 0) return 16'(top);
      return 16'($urandom_range(0, (top < 12) ? top : 12));
   endfunction

   task automatic randomize_registers();
      logic [31:0] lim;
      case ($urandom_range(0, 11))
         0:       lim = 32'd0;
         1:       lim = 32'd1;
         2:       lim = 32'd255;
         3:       lim = 32'd200;
         default: lim = $urandom_range(8, 200);
      endcase
      wait_idle();
      csr_write(REG_CRC8_POLY,  biased_word());
      csr_write(REG_CRC16_POLY, biased_word());
      csr_write(REG_LEN_LIMIT,  lim);
      csr_write(REG_GIMBAL_CMD, biased_word());
      csr_write(REG_GIMBAL_LEN, $urandom_range(0, 12));
      csr_write(REG_HBEAT_CMD,  biased_word());
      csr_write(REG_HBEAT_LEN,  $urandom_range(0, 12));
      settings_used++;
   endtask

   // Well-formed frames dominate; the rest are faults, rejects and noise.
   task automatic send_random_frame();
      int unsigned  pick;
      logic [15:0]  cmd;
      logic [15:0]  len16;
      frame_fault_e fault;
      pick  = $urandom_range(0, 99);
      cmd   = $urandom;
      len16 = pick_length();
      fault = FRAME_INTACT;
      if (pick < 20) begin
         cmd = cfg_model.gimbal_cmd;
         if ($urandom_range(0, 2) != 0) len16 = cfg_model.gimbal_len;
      end else if (pick < 35) begin
         cmd = cfg_model.heartbeat_cmd;
         if ($urandom_range(0, 2) != 0) len16 = cfg_model.heartbeat_len;
      end else if (pick < 45) begin
         fault = FRAME_BAD_FRM_CRC;
      end else if (pick < 52) begin
         fault = FRAME_BAD_HDR_CRC;
      end else if (pick < 58) begin
         len16 = $urandom_range(cfg_model.length_limit, 16'hFFFF);
      end
      if (pick >= 58 && pick < 64) begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
         send_frame(cmd, len16, fault);
      end
   endtask

   // ------------------------------------------------------- test cases
   // Bytes seen while hunting, including near misses of the start byte.
   task automatic test_hunting_noise();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      send_byte(8'hA4);
   endtask

   // Length high byte set, length at the limit, bad header CRC, empty frame, bad frame CRC.
   task automatic test_frame_checks();
      send_frame(16'h0001, 16'h0100, FRAME_INTACT);
      send_frame(16'h0002, 16'd200, FRAME_INTACT);
      send_frame(16'h0003, 16'd2, FRAME_BAD_HDR_CRC);
      send_frame(16'h0004, 16'd0, FRAME_INTACT);
      send_frame(16'h0005, 16'd3, FRAME_BAD_FRM_CRC);
   endtask

   // Gimbal, heartbeat, length mismatch, both matching, longest frame.
   task automatic test_match_kinds();
      wait_idle();
      csr_write(REG_GIMBAL_CMD, 32'h1234);
      csr_write(REG_GIMBAL_LEN, 32'd4);
      csr_write(REG_HBEAT_CMD,  32'hBEEF);
      csr_write(REG_HBEAT_LEN,  32'd0);
      settings_used++;
      send_frame(16'h1234, 16'd4, FRAME_INTACT);
      send_frame(16'hBEEF, 16'd0, FRAME_INTACT);
      send_frame(16'h1234, 16'd5, FRAME_INTACT);
      wait_idle();
      csr_write(REG_HBEAT_CMD, 32'h1234);
      csr_write(REG_HBEAT_LEN, 32'd4);
      settings_used++;
      send_frame(16'h1234, 16'd4, FRAME_INTACT);
      send_frame(16'hFFFF, 16'd199, FRAME_INTACT);
   endtask

   // Zero and all-ones polynomials, limit 0, 1 and 255, the unmapped index.
   task automatic test_register_extremes();
      wait_idle();
      csr_write(REG_CRC8_POLY,  32'h0);
      csr_write(REG_CRC16_POLY, 32'h0);
      csr_write(REG_LEN_LIMIT,  32'd0);
      settings_used++;
      send_frame(16'h0000, 16'd0, FRAME_INTACT);
      wait_idle();
      csr_write(REG_LEN_LIMIT, 32'd1);
      settings_used++;
      send_frame(16'h00FF, 16'd0, FRAME_INTACT);
      send_frame(16'h00FF, 16'd1, FRAME_INTACT);
      wait_idle();
      // upper bits beyond each register's width must be dropped
      csr_write(REG_CRC8_POLY,  32'hFFFF_FFFF);
      csr_write(REG_CRC16_POLY, 32'hFFFF_FFFF);
      csr_write(REG_LEN_LIMIT,  32'hFFFF_FFFF);
      csr_write(REG_SPARE,      $urandom);
      settings_used++;
      send_frame(16'hA5A5, 16'd247, FRAME_INTACT);
      send_frame(16'hA5A5, 16'd248, FRAME_INTACT);
      wait_idle();
      csr_write(REG_CRC8_POLY,  32'h8C);
      csr_write(REG_CRC16_POLY, 32'h8408);
      csr_write(REG_LEN_LIMIT,  32'd200);
      settings_used++;
   endtask

   // Receiver stops for a long stretch while the sender keeps offering,
   // so the output buffer fills and req_tready must drop.
   task automatic test_output_backpressure();
      src_idle_on  = 1'b0;
      hold_cycles  = 300;
      hold_request = 1'b1;
      send_frame(16'h0BAD, 16'd40, FRAME_INTACT);
      src_idle_on  = 1'b1;
   endtask

   task automatic test_random_traffic();
      int unsigned stop_at;
      stop_at = bytes_sent + 820;
      randomize_registers();
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 11) == 0) randomize_registers();
         send_random_frame();
      end
   endtask

   // Back-to-back on both sides at full rate.
   task automatic test_streaming_no_idle();
      int unsigned stop_at;
      stop_at = bytes_sent + 250;
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      while (bytes_sent < stop_at) send_random_frame();
   endtask

   // ------------------------------------------------------- main sequence
   initial begin : run_tests
      // model state and register defaults after reset
      cfg_model.crc8_poly     = 8'h8C;
      cfg_model.crc16_poly    = 16'h8408;
      cfg_model.length_limit  = 8'd200;
      cfg_model.gimbal_cmd    = 16'd0;
      cfg_model.gimbal_len    = 8'd0;
      cfg_model.heartbeat_cmd = 16'd0;
      cfg_model.heartbeat_len = 8'd0;
      rx_phase   = PH_HUNT;
      body_count = 8'd0;
      len_reg    = 8'd0;
      len_low_q  = 8'd0;
      hdr_crc_q  = HDR_CRC_INIT;
      frm_crc_q  = FRM_CRC_INIT;
      cmd_q      = 16'd0;
      crc_lo_q   = 8'd0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_hunting_noise();
      test_frame_checks();
      test_match_kinds();
      test_register_extremes();
      test_output_backpressure();
      test_random_traffic();
      test_streaming_no_idle();

      // drain, then keep clocking so stray results still show up
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Run covered %0d frames, %0d bytes, %0d register settings, %0d results.",
               frames_sent, bytes_sent, settings_used, results_checked);
      $display("Events seen: %0d good, %0d frame CRC bad, %0d header CRC bad, %0d rejected.",
               event_tally[EV_FRAME_GOOD], event_tally[EV_FRAME_CRC_BAD],
               event_tally[EV_HDR_CRC_BAD], event_tally[EV_LEN_REJECT]);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #10_000_000;
      $display("Timeout with %0d results still owed", pending_rx_results.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
